FILE: hdl/hfp_pkg.sv
// Shared types and constants for the header/length/XOR frame parser.
// No dependencies; imported by hfp_core and header_frame_parser_xor_check.
package hfp_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic       payload_first;
		logic       frame_end;
		logic       frame_good;
		logic       timed_out;
	} result_t;

	localparam logic       KIND_BYTE = 1'b0;
	localparam logic       KIND_TICK = 1'b1;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_N    = 3'd1;
	localparam logic [2:0] PH_E    = 3'd2;
	localparam logic [2:0] PH_R    = 3'd3;
	localparam logic [2:0] PH_LEN  = 3'd4;
	localparam logic [2:0] PH_TOK  = 3'd5;
	localparam logic [2:0] PH_PAY  = 3'd6;

	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Fixed part of the checksum: header letters and ':'
	localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

	localparam logic [7:0] RELOAD_RST = 8'd5;

endpackage

FILE: hdl/header_frame_parser_xor_check.sv
// Top level of the serial frame parser: input stage, config register, result stage.
// Depends on hfp_pkg and hfp_core.
//
//  channel   direction  handshake            payload
//  item      in         item_valid/stall     item_t   (kind, rx_byte)
//  result    out        result_valid/stall   result_t (payload and frame flags)
//  cfg       in         cfg_valid/ready      cfg_data (timeout reload, 8 bit)
//
// An item beat passes through the input register, then the parser step logic into the
// result register. One item per cycle sustained while result_stall stays low.
// arst_n clears the stage valids, the parser state and sets the reload to 5.
// A stalled result holds the result register; the input stage then fills and
// item_stall rises only once both stages hold a beat. cfg_ready is always high.
module header_frame_parser_xor_check import hfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic       valid_s1;
	item_t      item_s1;
	logic [7:0] reload_q;
	logic       advance;
	logic       fire;
	result_t    step_res;

	assign cfg_ready  = 1'b1;
	assign advance    = !result_valid || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			reload_q <= RELOAD_RST;
		else if (cfg_valid && cfg_ready)
			reload_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid)
			item_s1 <= item;
	end

	hfp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.reload (reload_q),
		.res    (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			result <= step_res;
	end

	// a stall toward the source only happens with both stages full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("item_stall without a full pipeline");

	// at most one kind of event per result beat
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.payload_valid, result.frame_end, result.timed_out}))
		else $error("result carries more than one event");

	a_good_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_good) |-> result.frame_end)
		else $error("frame_good without frame_end");

	// a stage-1 beat is never dropped: it either moves on or stays put
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage lost its beat");

endmodule

FILE: hdl/hfp_core.sv
// Parser state registers and the per-beat next-state / result logic.
// Depends on hfp_pkg.
module hfp_core import hfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  item_t      item,
	input  logic [7:0] reload,
	output result_t    res
);

	logic [2:0] phase_q,  phase_d;
	logic [7:0] bytes_q,  bytes_d;
	logic [7:0] xor_q,    xor_d;
	logic [7:0] ticks_q,  ticks_d;
	logic       first_q,  first_d;

	logic [7:0] b;
	logic       hit_u;
	logic [7:0] ticks_dec;
	logic [7:0] bytes_dec;

	assign b         = item.rx_byte;
	assign hit_u     = (b == CH_U);
	assign ticks_dec = ticks_q - 8'd1;
	assign bytes_dec = bytes_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		bytes_d = bytes_q;
		xor_d   = xor_q;
		ticks_d = ticks_q;
		first_d = first_q;
		res     = '0;
		if (item.kind == KIND_TICK) begin
			if (phase_q != PH_IDLE) begin
				ticks_d = ticks_dec;
				if (ticks_dec == 8'd0) begin
					phase_d       = PH_IDLE;
					first_d       = 1'b0;
					res.timed_out = 1'b1;
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (hit_u) begin
						phase_d = PH_N;
						ticks_d = reload;
					end
				end
				PH_N: begin
					if (b == CH_N)
						phase_d = PH_E;
					else if (!hit_u)
						phase_d = PH_IDLE;
				end
				PH_E, PH_R, PH_TOK: begin
					if (phase_q == PH_E && b == CH_E) begin
						phase_d = PH_R;
					end else if (phase_q == PH_R && b == CH_R) begin
						phase_d = PH_LEN;
					end else if (phase_q == PH_TOK && b == CH_COLON) begin
						phase_d = PH_PAY;
						xor_d   = HDR_XOR ^ bytes_q;
						first_d = 1'b1;
					end else if (hit_u) begin
						// mismatch: the same byte is looked at again from idle
						phase_d = PH_N;
						ticks_d = reload;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_LEN: begin
					bytes_d = b;
					phase_d = PH_TOK;
				end
				PH_PAY: begin
					bytes_d = bytes_dec;
					if (bytes_dec != 8'd0) begin
						xor_d             = xor_q ^ b;
						res.payload_valid = 1'b1;
						res.payload_byte  = b;
						res.payload_first = first_q;
						first_d           = 1'b0;
					end else begin
						phase_d        = PH_IDLE;
						first_d        = 1'b0;
						res.frame_end  = 1'b1;
						res.frame_good = (b == xor_q);
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bytes_q <= '0;
			xor_q   <= '0;
			ticks_q <= '0;
			first_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			bytes_q <= bytes_d;
			xor_q   <= xor_d;
			ticks_q <= ticks_d;
			first_q <= first_d;
		end
	end

endmodule

FILE: verif/frame_parser_checker.sv
// Scoreboard for header_frame_parser_xor_check: watches the item, result and cfg channels,
// runs its own copy of the parser and compares every result beat field by field.
// Depends on hfp_pkg.
module frame_parser_checker import hfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  item_t      item,
	input  logic       result_valid,
	input  logic       result_stall,
	input  result_t    result,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         pending,
	output int         frames_ok,
	output int         frames_bad,
	output int         timeouts,
	output int         payload_bytes
);

	logic [7:0] reload_copy;
	logic [2:0] phase;
	logic [7:0] count_left;
	logic [7:0] xor_acc;
	logic [7:0] tick_count;
	logic       id_next;
	result_t    results_due[$];

	// Back to idle, then look at the same byte again
	task automatic restart_on(input logic [7:0] b);
		phase = PH_IDLE;
		if (b == CH_U) begin
			phase = PH_N;
			tick_count = reload_copy;
		end
	endtask

	task automatic parse_step(input item_t it, output result_t r);
		logic [7:0] b;
		b = it.rx_byte;
		r = '0;
		if (it.kind == KIND_TICK) begin
			if (phase != PH_IDLE) begin
				tick_count = tick_count - 8'd1;
				if (tick_count == 8'd0) begin
					phase = PH_IDLE;
					id_next = 1'b0;
					r.timed_out = 1'b1;
					timeouts++;
				end
			end
		end else begin
			case (phase)
				PH_IDLE: restart_on(b);
				PH_N: begin
					// a repeated U keeps waiting for N without a reload
					if (b == CH_N)
						phase = PH_E;
					else if (b != CH_U)
						phase = PH_IDLE;
				end
				PH_E: begin
					if (b == CH_E)
						phase = PH_R;
					else
						restart_on(b);
				end
				PH_R: begin
					if (b == CH_R)
						phase = PH_LEN;
					else
						restart_on(b);
				end
				PH_LEN: begin
					count_left = b;
					phase = PH_TOK;
				end
				PH_TOK: begin
					if (b == CH_COLON) begin
						phase = PH_PAY;
						xor_acc = HDR_XOR ^ count_left;
						id_next = 1'b1;
					end else begin
						restart_on(b);
					end
				end
				PH_PAY: begin
					// length 0 wraps, giving 255 payload bytes
					count_left = count_left - 8'd1;
					if (count_left != 8'd0) begin
						xor_acc = xor_acc ^ b;
						r.payload_valid = 1'b1;
						r.payload_byte = b;
						r.payload_first = id_next;
						id_next = 1'b0;
						payload_bytes++;
					end else begin
						phase = PH_IDLE;
						id_next = 1'b0;
						r.frame_end = 1'b1;
						r.frame_good = (b == xor_acc);
						if (b == xor_acc)
							frames_ok++;
						else
							frames_bad++;
					end
				end
				default: phase = PH_IDLE;
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t r;
		if (!arst_n) begin
			reload_copy = RELOAD_RST;
			phase = PH_IDLE;
			count_left = '0;
			xor_acc = '0;
			tick_count = '0;
			id_next = 1'b0;
			results_due.delete();
			errors = 0;
			pending = 0;
			frames_ok = 0;
			frames_bad = 0;
			timeouts = 0;
			payload_bytes = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reload_copy = cfg_data;
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, expected none, actual %h",
						$time, result);
				end else begin
					want = results_due.pop_front();
					check_field("payload_valid", 8'(want.payload_valid),
						8'(result.payload_valid));
					check_field("payload_byte", want.payload_byte, result.payload_byte);
					check_field("payload_first", 8'(want.payload_first),
						8'(result.payload_first));
					check_field("frame_end", 8'(want.frame_end), 8'(result.frame_end));
					check_field("frame_good", 8'(want.frame_good), 8'(result.frame_good));
					check_field("timed_out", 8'(want.timed_out), 8'(result.timed_out));
				end
			end
			if (item_valid && !item_stall) begin
				parse_step(item, r);
				results_due.push_back(r);
			end
			pending = results_due.size();
		end
	end

endmodule

FILE: verif/tb.sv
// Testbench top for header_frame_parser_xor_check: clock, reset, byte/tick stimulus,
// reload writes and random stalls; the verdict comes from frame_parser_checker.
// Depends on hfp_pkg, header_frame_parser_xor_check and frame_parser_checker.
module tb;
	import hfp_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	int errors, pending, frames_ok, frames_bad, timeouts, payload_bytes;
	int items_sent = 0;
	int gap_pct = 25;
	int stall_pct = 25;
	bit hold_req = 1'b0;
	logic [7:0] cur_reload = RELOAD_RST;

	header_frame_parser_xor_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	frame_parser_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.frames_ok(frames_ok),
		.frames_bad(frames_bad),
		.timeouts(timeouts),
		.payload_bytes(payload_bytes)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request so the input backs up
	initial begin
		int held;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				for (held = 0; held < 60; held++)
					@(posedge clk);
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_item(input logic k, input logic [7:0] b);
		while ($urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{kind: k, rx_byte: b};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(KIND_BYTE, b);
	endtask

	task automatic send_tick();
		send_item(KIND_TICK, 8'($urandom));
	endtask

	// Full frame with random payload; a few ticks may fall inside it
	task automatic send_frame(input logic [7:0] len, input bit good, input int ticks_allowed);
		logic [7:0] sum;
		logic [7:0] b;
		int n;
		n = (len == 8'd0) ? 255 : len - 1;
		send_byte(CH_U);
		send_byte(CH_N);
		send_byte(CH_E);
		send_byte(CH_R);
		send_byte(len);
		send_byte(CH_COLON);
		sum = HDR_XOR ^ len;
		repeat (n) begin
			if (ticks_allowed > 0 && $urandom_range(0, 9) == 0) begin
				send_tick();
				ticks_allowed--;
			end
			b = 8'($urandom);
			sum = sum ^ b;
			send_byte(b);
		end
		send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	task automatic random_traffic(input int quota);
		int stop_at;
		int sel;
		int p;
		int depth;
		int burst;
		logic [7:0] len;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			p = $urandom_range(0, 99);
			len = (p < 80) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(9, 40));
			if (sel < 60) begin
				send_frame(len, $urandom_range(0, 3) != 0, $urandom_range(0, 2));
			end else if (sel < 68) begin
				repeat ($urandom_range(1, 3))
					send_byte(CH_U);
				send_frame(len, 1'b1, 0);
			end else if (sel < 78) begin
				// header cut short, then a stray byte that may be a new U
				depth = $urandom_range(0, 4);
				send_byte(CH_U);
				if (depth > 0) send_byte(CH_N);
				if (depth > 1) send_byte(CH_E);
				if (depth > 2) send_byte(CH_R);
				if (depth > 3) send_byte(len);
				send_byte($urandom_range(0, 1) ? CH_U : 8'($urandom));
			end else if (sel < 88) begin
				burst = (cur_reload == 8'd0 || cur_reload > 8'd12) ? 12 : cur_reload + 1;
				send_byte(CH_U);
				repeat ($urandom_range(1, burst))
					send_tick();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 1))
						send_tick();
					else
						send_byte(8'($urandom));
				end
			end
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_reload(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_reload = v;
	endtask

	initial begin
		logic [7:0] seq[$];
		logic [7:0] settings[6];
		int i;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tick while idle, length one, repeated U with byte extremes,
		// token mismatch restarting on U, then timeout at the reset reload
		send_tick();
		send_frame(8'd1, 1'b1, 0);
		seq = '{CH_U, CH_U, CH_N, CH_E, CH_R, 8'h02, CH_COLON, 8'hFF, HDR_XOR ^ 8'h02 ^ 8'hFF};
		foreach (seq[j])
			send_byte(seq[j]);
		seq = '{CH_U, CH_N, CH_E, CH_R, 8'h00, CH_U};
		foreach (seq[j])
			send_byte(seq[j]);
		repeat (5)
			send_tick();

		settings = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(4, 254)), 8'd2};
		for (i = 0; i < 6; i++) begin
			drain();
			write_reload(settings[i]);
			gap_pct = (i == 3) ? 0 : 25;
			stall_pct = (i == 3) ? 0 : 25;
			if (i == 1)
				hold_req = 1'b1;
			if (settings[i] == 8'd0) begin
				// longest timeout, then the longest frame
				send_byte(CH_U);
				repeat (256)
					send_tick();
				send_frame(settings[i], 1'b1, 0);
			end
			random_traffic((i == 3) ? 60 : 20);
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d beats over reloads 5,1,255,0,3,%0d,2 with random stalls and one hold-off",
			items_sent, settings[4]);
		$display("Frames good %0d, bad checksum %0d, timeouts %0d, payload bytes %0d",
			frames_ok, frames_bad, timeouts, payload_bytes);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
